// ===== design/rsst_pkg.sv =====
// Package for the range-sum segment tree: shared types and constants.
// Depends on nothing.
`default_nettype none
package rsst_pkg;
	localparam int IDX_W = 10;
	localparam int VAL_W = 32;
	localparam int SUM_W = 64;

	// one classified command passed from front to back
	typedef struct packed {
		logic             is_query;
		logic             bad;
		logic             empty;
		logic [IDX_W-1:0] pos;
		logic [VAL_W-1:0] value;
		logic [IDX_W-1:0] lo;
		logic [IDX_W-1:0] hi;
	} cmd_t;
endpackage
`default_nettype wire

// ===== design/rsst_front.sv =====
// Front end: accepts items, checks indexes, queues commands for the back end.
// Depends on rsst_pkg.
`default_nettype none
module rsst_front #(
	parameter int ENTRIES = 1024
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	output logic                       busy,
	input  wire                        kind,
	input  wire  [rsst_pkg::IDX_W-1:0] position,
	input  wire  [rsst_pkg::VAL_W-1:0] value,
	input  wire  [rsst_pkg::IDX_W-1:0] range_low,
	input  wire  [rsst_pkg::IDX_W-1:0] range_high,
	output logic                       cmd_valid,
	output rsst_pkg::cmd_t             cmd,
	input  wire                        cmd_pop
);
	localparam int DEPTH = 2;

	rsst_pkg::cmd_t       fifo_q [DEPTH];
	logic                 wp_q, rp_q;
	logic [1:0]           cnt_q;
	logic                 push;
	rsst_pkg::cmd_t       in_cmd;
	logic                 lo_bad, hi_bad, pos_bad;

	assign busy = (cnt_q == 2'(DEPTH));
	assign push = start && !busy;

	// index checks against the stored entry count
	always_comb begin
		pos_bad = (32'(position) >= 32'(ENTRIES));
		lo_bad = (32'(range_low) >= 32'(ENTRIES));
		hi_bad = (32'(range_high) >= 32'(ENTRIES));
		in_cmd.is_query = kind;
		in_cmd.bad = kind ? (lo_bad || hi_bad) : pos_bad;
		in_cmd.empty = range_low > range_high;
		in_cmd.pos = position;
		in_cmd.value = value;
		in_cmd.lo = range_low;
		in_cmd.hi = range_high;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (cmd_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end

	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = fifo_q[rp_q];
endmodule
`default_nettype wire

// ===== design/rsst_back.sv =====
// Back end: walks the tree one node access per cycle for updates and queries.
// Depends on rsst_pkg.
`default_nettype none
module rsst_back #(
	parameter int ENTRIES = 1024
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cmd_valid,
	input  rsst_pkg::cmd_t             cmd,
	output logic                       cmd_pop,
	output logic                       done,
	output logic [rsst_pkg::SUM_W-1:0] range_sum,
	output logic                       bad_index
);
	localparam int LW = $clog2(ENTRIES);
	localparam int AW = LW + 1;          // node address width
	localparam int NN = 2 * ENTRIES;
	localparam int SW = rsst_pkg::SUM_W;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_CLEAR = 8'b00000010,
		ST_ULEAF = 8'b00000100,
		ST_URD   = 8'b00001000,
		ST_UWAIT = 8'b00010000,
		ST_UWR   = 8'b00100000,
		ST_QSTEP = 8'b01000000,
		ST_QACC  = 8'b10000000
	} state_t;

	logic [SW-1:0]  mem [NN];
	state_t         st_q;
	logic [AW:0]    a_q, b_q;            // one extra bit: b can reach 2*ENTRIES
	logic [AW-1:0]  k_q;
	logic [SW-1:0]  acc_q, rd_q;
	logic           we;
	logic [AW-1:0]  wa, ra;
	logic [SW-1:0]  wd;
	logic [AW:0]    clr_q;
	logic           take_a_q, take_b_q;

	// node memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	always_comb begin
		we = 1'b0;
		wa = k_q;
		wd = acc_q;
		ra = k_q ^ AW'(1);
		unique case (st_q)
			ST_CLEAR: begin
				we = 1'b1;
				wa = clr_q[AW-1:0];
				wd = '0;
			end
			ST_ULEAF: begin
				we = 1'b1;
				wa = k_q;
				wd = acc_q;
				ra = k_q ^ AW'(1);
			end
			ST_UWR: begin
				we = 1'b1;
				wa = k_q;
				wd = acc_q;
				ra = k_q ^ AW'(1);
			end
			ST_QSTEP: ra = take_a_q ? a_q[AW-1:0] : b_q[AW-1:0] - AW'(1);
			default: ;
		endcase
	end

	assign cmd_pop = (st_q == ST_IDLE) && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			clr_q <= '0;
			done <= 1'b0;
			range_sum <= '0;
			bad_index <= 1'b0;
			a_q <= '0;
			b_q <= '0;
			k_q <= '0;
			acc_q <= '0;
			take_a_q <= 1'b0;
			take_b_q <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				// sweep zero through every node after reset
				ST_CLEAR: begin
					clr_q <= clr_q + (AW+1)'(1);
					if (clr_q == (AW+1)'(NN - 1)) st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						if (cmd.bad || (cmd.is_query && cmd.empty)) begin
							done <= 1'b1;
							range_sum <= '0;
							bad_index <= cmd.bad;
						end else if (!cmd.is_query) begin
							k_q <= AW'(ENTRIES) + AW'(cmd.pos);
							acc_q <= SW'(signed'(cmd.value));
							st_q <= (ENTRIES == 1) ? ST_UWR : ST_ULEAF;
						end else begin
							a_q <= (AW+1)'(ENTRIES) + (AW+1)'(cmd.lo);
							b_q <= (AW+1)'(ENTRIES) + (AW+1)'(cmd.hi) + (AW+1)'(1);
							acc_q <= '0;
							take_a_q <= 1'b0;
							take_b_q <= 1'b0;
							st_q <= ST_QACC;
						end
					end
				end
				// leaf written; sibling read issued this cycle
				ST_ULEAF: st_q <= ST_URD;
				ST_URD: begin
					acc_q <= acc_q + rd_q;
					k_q <= k_q >> 1;
					st_q <= ST_UWR;
				end
				// parent written; its sibling read issued this cycle
				ST_UWR: begin
					if (k_q == AW'(1)) begin
						done <= 1'b1;
						range_sum <= '0;
						bad_index <= 1'b0;
						st_q <= ST_IDLE;
					end else begin
						st_q <= ST_URD;
					end
				end
				ST_UWAIT: st_q <= ST_IDLE;
				// issue reads for odd a, then for b-1 when b is odd, then climb a level
				ST_QACC: begin
					if (take_a_q || take_b_q) begin
						acc_q <= acc_q + rd_q;
					end
					take_a_q <= 1'b0;
					take_b_q <= 1'b0;
					if (a_q < b_q) begin
						if (a_q[0]) begin
							take_a_q <= 1'b1;
							st_q <= ST_QSTEP;
						end else if (b_q[0]) begin
							take_b_q <= 1'b1;
							st_q <= ST_QSTEP;
						end else begin
							a_q <= a_q >> 1;
							b_q <= b_q >> 1;
						end
					end else if (!(take_a_q || take_b_q)) begin
						done <= 1'b1;
						range_sum <= acc_q;
						bad_index <= 1'b0;
						st_q <= ST_IDLE;
					end else begin
						st_q <= ST_QACC;
					end
				end
				ST_QSTEP: begin
					if (take_a_q) a_q <= a_q + (AW+1)'(1);
					else b_q <= b_q - (AW+1)'(1);
					st_q <= ST_QACC;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== design/range_sum_segment_tree_top.sv =====
// Top level of the range-sum segment tree: front classifier, command queue, tree walker.
// Updates climb from the leaf to the root; queries climb the tree a level at a time, with a read
// step for each node taken; bad or empty items are answered without a walk. One node access per cycle.
// One item at a time in the walker; the front queue holds two more and raises busy when full.
// After reset a clearing pass zeroes every node of the tree; items queue meanwhile.
// Depends on rsst_pkg, rsst_front, rsst_back.
`default_nettype none
module range_sum_segment_tree_top #(
	parameter int ENTRIES = 1024
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire         kind,
	input  wire  [9:0]  position,
	input  wire  [31:0] value,
	input  wire  [9:0]  range_low,
	input  wire  [9:0]  range_high,
	output logic        done,
	output logic [63:0] range_sum,
	output logic        bad_index
);
	logic           cmd_valid, cmd_pop;
	rsst_pkg::cmd_t cmd;

	rsst_front #(.ENTRIES(ENTRIES)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.position(position), .value(value), .range_low(range_low),
		.range_high(range_high), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
	);

	rsst_back #(.ENTRIES(ENTRIES)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd),
		.cmd_pop(cmd_pop), .done(done), .range_sum(range_sum), .bad_index(bad_index)
	);
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for range_sum_segment_tree_top: random and directed updates and range queries,
// checked against a flat-array model of the leaves held in a scoreboard class.
// Depends on range_sum_segment_tree_top.
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard: a flat array of leaves stands in for the tree; sums are taken directly.
class sum_scoreboard;
	logic [63:0] leaf_vals [1024];
	logic [63:0] want_sum [$];
	logic        want_bad [$];
	int          mismatches;

	function new();
		foreach (leaf_vals[i]) leaf_vals[i] = '0;
		mismatches = 0;
	endfunction

	// note an accepted command and queue its expected result
	function void note_command(logic kind, logic [9:0] pos, logic [31:0] val,
			logic [9:0] lo, logic [9:0] hi);
		logic [63:0] acc;
		acc = '0;
		if (kind == 1'b0) begin
			leaf_vals[pos] = {{32{val[31]}}, val};
		end else if (lo <= hi) begin
			for (int i = lo; i <= hi; i++) acc = acc + leaf_vals[i];
		end
		// all 10-bit indexes lie inside 1024 entries, so bad_index stays low
		want_sum.push_back(acc);
		want_bad.push_back(1'b0);
	endfunction

	function void report(string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endfunction

	// compare one result with the oldest expectation
	function void check_result(logic [63:0] sum, logic bad);
		logic [63:0] es;
		logic        eb;
		if (want_sum.size() == 0) begin
			report($sformatf("unexpected result sum=%h bad=%b", sum, bad));
			return;
		end
		es = want_sum.pop_front();
		eb = want_bad.pop_front();
		if (sum !== es) report($sformatf("range_sum %h, expected %h", sum, es));
		if (bad !== eb) report($sformatf("bad_index %b, expected %b", bad, eb));
	endfunction
endclass

module testbench;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        kind = 1'b0;
	logic [9:0]  position = '0;
	logic [31:0] value = '0;
	logic [9:0]  range_low = '0;
	logic [9:0]  range_high = '0;
	wire         busy;
	wire         done;
	wire  [63:0] range_sum;
	wire         bad_index;
	bit          steady;
	sum_scoreboard sb = new();

	range_sum_segment_tree_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.position(position), .value(value), .range_low(range_low),
		.range_high(range_high), .done(done), .range_sum(range_sum),
		.bad_index(bad_index)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(range_sum, bad_index);
	end

	// one command transfer, with an optional random gap first
	task automatic issue(logic k, logic [9:0] p, logic [31:0] v, logic [9:0] lo,
			logic [9:0] hi);
		while (!steady && $urandom_range(99) < 34) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		position <= p;
		value <= v;
		range_low <= lo;
		range_high <= hi;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_command(k, p, v, lo, hi);
	endtask

	task automatic random_value(output logic [31:0] v);
		case ($urandom_range(3))
			0: v = 32'h7FFF_FFFF;
			1: v = 32'h8000_0000;
			default: v = $urandom;
		endcase
	endtask

	initial begin
		logic [31:0] v;
		logic [9:0]  a, b;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		steady = 1'b0;
		// directed: extremes, empty and full ranges, wraparound of the sum
		issue(1'b1, 10'd0, 32'd0, 10'd0, 10'd1023);
		issue(1'b0, 10'd0, 32'h7FFF_FFFF, 10'd0, 10'd0);
		issue(1'b0, 10'd1023, 32'h8000_0000, 10'd0, 10'd0);
		issue(1'b0, 10'd512, 32'hFFFF_FFFF, 10'd0, 10'd0);
		issue(1'b1, 10'd0, 32'd0, 10'd0, 10'd1023);
		issue(1'b1, 10'd0, 32'd0, 10'd0, 10'd0);
		issue(1'b1, 10'd0, 32'd0, 10'd1023, 10'd1023);
		issue(1'b1, 10'd0, 32'd0, 10'd1023, 10'd0);
		issue(1'b1, 10'd0, 32'd0, 10'd5, 10'd4);
		issue(1'b1, 10'd0, 32'd0, 10'd1, 10'd1022);
		issue(1'b0, 10'd0, 32'h0000_0001, 10'd1023, 10'd1023);
		issue(1'b1, 10'h3FF, 32'hFFFF_FFFF, 10'd511, 10'd513);
		// random: only updates for the first 150 items, then a mix
		for (int n = 0; n < 500; n++) begin
			steady = (n >= 200 && n < 280);
			random_value(v);
			a = 10'($urandom);
			b = 10'($urandom);
			if ($urandom_range(3) == 0) b = 10'(a + $urandom_range(7));
			if (n < 150 || $urandom_range(1)) issue(1'b0, a, v, b, a);
			else issue(1'b1, 10'($urandom), v, a, b);
		end
		start <= 1'b0;
		while (sb.want_sum.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end
endmodule

// ===== filelist.f =====
design/rsst_pkg.sv
design/rsst_front.sv
design/rsst_back.sv
design/range_sum_segment_tree_top.sv
tb/testbench.sv
